[hw/rtl/whdm_pkg.sv]
// Package for the windowed Hamming descriptor matcher.
// Holds the transfer payload types, opcodes, register indexes and the popcount helper.
// No dependencies.
package whdm_pkg;

    // Widths fixed by the item format
    localparam int COORD_W    = 12;
    localparam int DESC_MAX   = 256;
    localparam int DIST_W     = 9;
    localparam int OUT_IDX_W  = 10;
    localparam int CFG_IDX_W  = 2;

    // Opcodes of an input item
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF = 2'd2;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_IMAGE_COLS  = 12'd640;
    localparam logic [COORD_W-1:0] RST_IMAGE_ROWS  = 12'd480;
    localparam logic [COORD_W-1:0] RST_WINDOW_HALF = 12'd100;

    // Distance reported when nothing matches
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 9'd256;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [63:0]        desc_word0;
        logic [63:0]        desc_word1;
        logic [63:0]        desc_word2;
        logic [63:0]        desc_word3;
    } t_in_item;

    typedef struct packed {
        logic                 matched;
        logic [OUT_IDX_W-1:0] match_index;
        logic [DIST_W-1:0]    best_distance;
    } t_out_item;

    // One scanned store entry as seen by the best-match tracker
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [DIST_W-1:0] distance;
    } t_cand;

    // Count the set bits of one 64-bit word: per-byte counts, then an adder tree
    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [3:0] b [8];
        logic [6:0] s;
        for (int k = 0; k < 8; k++) begin
            b[k] = '0;
            for (int j = 0; j < 8; j++) begin
                b[k] = b[k] + 4'(v[k*8 + j]);
            end
        end
        s = ((7'(b[0]) + 7'(b[1])) + (7'(b[2]) + 7'(b[3])))
          + ((7'(b[4]) + 7'(b[5])) + (7'(b[6]) + 7'(b[7])));
        return s;
    endfunction

endpackage

[hw/rtl/whdm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module whdm_ram #(
    parameter int WIDTH = 280,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/whdm_dist.sv]
// Two-stage window test and Hamming distance unit for one store entry per cycle.
// Depends on whdm_pkg (t_cand, pop64, widths).
module whdm_dist #(
    parameter int DESC_BITS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [whdm_pkg::COORD_W-1:0] i_ref_x,
    input  logic [whdm_pkg::COORD_W-1:0] i_ref_y,
    input  logic [DESC_BITS-1:0]         i_ref_desc,
    input  logic [whdm_pkg::COORD_W-1:0] i_qry_x,
    input  logic [whdm_pkg::COORD_W-1:0] i_qry_y,
    input  logic [DESC_BITS-1:0]         i_qry_desc,
    input  logic [whdm_pkg::COORD_W-1:0] i_window_half,
    output whdm_pkg::t_cand              o_cand
);

    logic [whdm_pkg::COORD_W-1:0] w_dx;
    logic [whdm_pkg::COORD_W-1:0] w_dy;
    logic [whdm_pkg::DESC_MAX-1:0] w_diff;

    logic       r_a_valid;
    logic       r_a_hit;
    logic [6:0] r_a_pop [4];

    whdm_pkg::t_cand r_cand;

    // Absolute coordinate offsets and differing descriptor bits
    assign w_dx = (i_ref_x > i_qry_x) ? (i_ref_x - i_qry_x) : (i_qry_x - i_ref_x);
    assign w_dy = (i_ref_y > i_qry_y) ? (i_ref_y - i_qry_y) : (i_qry_y - i_ref_y);
    assign w_diff = whdm_pkg::DESC_MAX'(i_ref_desc ^ i_qry_desc);

    // Stage A: window test and per-word popcounts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_hit <= (w_dx < i_window_half) && (w_dy < i_window_half);
        for (int k = 0; k < 4; k++) begin
            r_a_pop[k] <= whdm_pkg::pop64(w_diff[k*64 +: 64]);
        end
    end

    // Stage B: total distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= r_a_valid;
        end
        r_cand.hit      <= r_a_hit;
        r_cand.distance <= whdm_pkg::DIST_W'(r_a_pop[0]) + whdm_pkg::DIST_W'(r_a_pop[1])
                         + whdm_pkg::DIST_W'(r_a_pop[2]) + whdm_pkg::DIST_W'(r_a_pop[3]);
    end

    assign o_cand = r_cand;

endmodule

[hw/rtl/windowed_hamming_descriptor_matcher_top.sv]
// Top level of the windowed Hamming descriptor matcher: control, config and best-match tracking.
// Depends on whdm_pkg, whdm_ram (reference store) and whdm_dist (distance pipeline).
//
//   channel | direction | transfer when              | payload
//   in      | input     | i_in_valid & !o_in_stall   | i_in_item  (whdm_pkg::t_in_item)
//   out     | output    | o_out_valid & !i_out_stall | o_out_item (whdm_pkg::t_out_item)
//   cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A query reads the store one entry per cycle through the single RAM read port; it skips
// the scan when the store is empty or the point lies outside the image.
// Reset is synchronous and active low; it empties the store and restores the registers.
// A finished result waits in the output register while the next item is taken; a new query
// result holds in the block until that register frees up.
module windowed_hamming_descriptor_matcher_top #(
    parameter int MAX_REFS  = 1024,
    parameter int DESC_BITS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  whdm_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output whdm_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [whdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [whdm_pkg::COORD_W-1:0]   i_cfg_data
);

    localparam int IDX_W   = $clog2(MAX_REFS);
    localparam int CNT_W   = $clog2(MAX_REFS + 1);
    localparam int ENTRY_W = 2 * whdm_pkg::COORD_W + DESC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state r_state;

    logic [whdm_pkg::COORD_W-1:0] r_image_cols;
    logic [whdm_pkg::COORD_W-1:0] r_image_rows;
    logic [whdm_pkg::COORD_W-1:0] r_window_half;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_addr;
    logic [1:0]       r_flush;
    logic             r_rd_v;

    logic [whdm_pkg::COORD_W-1:0] r_qx;
    logic [whdm_pkg::COORD_W-1:0] r_qy;
    logic [DESC_BITS-1:0]         r_qdesc;

    logic [whdm_pkg::DIST_W-1:0] r_best;
    logic [IDX_W-1:0]            r_best_idx;
    logic [IDX_W-1:0]            r_cand_idx;

    logic                r_out_valid;
    whdm_pkg::t_out_item r_out_item;

    logic                            w_in_xfer;
    logic [whdm_pkg::DESC_MAX-1:0]   w_in_desc;
    logic                            w_we;
    logic                            w_re;
    logic [ENTRY_W-1:0]              w_wdata;
    logic [ENTRY_W-1:0]              w_rdata;
    logic                            w_in_image;
    logic                            w_out_free;
    logic                            w_matched;
    whdm_pkg::t_cand                 w_cand;

    // Input transfer and entry packing
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_in_desc  = {i_in_item.desc_word3, i_in_item.desc_word2,
                         i_in_item.desc_word1, i_in_item.desc_word0};
    assign w_wdata    = {i_in_item.point_x, i_in_item.point_y, DESC_BITS'(w_in_desc)};
    assign w_we       = w_in_xfer && (i_in_item.opcode == whdm_pkg::OP_APPEND)
                        && (r_count < CNT_W'(MAX_REFS));
    assign w_re       = (r_state == S_SCAN);
    assign w_in_image = (i_in_item.point_x <= r_image_cols)
                        && (i_in_item.point_y <= r_image_rows);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_matched  = (r_best != whdm_pkg::NO_MATCH_DIST);

    whdm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REFS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    whdm_dist #(
        .DESC_BITS (DESC_BITS)
    ) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_rd_v),
        .i_ref_x       (w_rdata[ENTRY_W-1 -: whdm_pkg::COORD_W]),
        .i_ref_y       (w_rdata[DESC_BITS +: whdm_pkg::COORD_W]),
        .i_ref_desc    (w_rdata[DESC_BITS-1:0]),
        .i_qry_x       (r_qx),
        .i_qry_y       (r_qy),
        .i_qry_desc    (r_qdesc),
        .i_window_half (r_window_half),
        .o_cand        (w_cand)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols  <= whdm_pkg::RST_IMAGE_COLS;
            r_image_rows  <= whdm_pkg::RST_IMAGE_ROWS;
            r_window_half <= whdm_pkg::RST_WINDOW_HALF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                whdm_pkg::CFG_IMAGE_COLS:  r_image_cols  <= i_cfg_data;
                whdm_pkg::CFG_IMAGE_ROWS:  r_image_rows  <= i_cfg_data;
                whdm_pkg::CFG_WINDOW_HALF: r_window_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mark read data valid in the cycle after each issued read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_re;
        end
    end

    // Sequencer, store fill count, best-match tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_flush     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the held result once it transfers, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // Fold each scanned entry into the running best
            if (w_cand.valid) begin
                r_cand_idx <= r_cand_idx + IDX_W'(1);
                if (w_cand.hit && (w_cand.distance < r_best)) begin
                    r_best     <= w_cand.distance;
                    r_best_idx <= r_cand_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        unique case (i_in_item.opcode)
                            whdm_pkg::OP_CLEAR: begin
                                r_count <= '0;
                            end
                            whdm_pkg::OP_APPEND: begin
                                if (w_we) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            whdm_pkg::OP_QUERY: begin
                                r_qx       <= i_in_item.point_x;
                                r_qy       <= i_in_item.point_y;
                                r_qdesc    <= DESC_BITS'(w_in_desc);
                                r_best     <= whdm_pkg::NO_MATCH_DIST;
                                r_best_idx <= '0;
                                r_cand_idx <= '0;
                                r_addr     <= '0;
                                if (w_in_image && (r_count != '0)) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle up to the last stored entry
                    r_addr <= r_addr + IDX_W'(1);
                    if (r_addr == IDX_W'(r_count - CNT_W'(1))) begin
                        r_flush <= '0;
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    // Let the read and distance stages drain
                    r_flush <= r_flush + 2'd1;
                    if (r_flush == 2'd2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_item.matched       <= w_matched;
                        r_out_item.match_index   <= w_matched
                                                    ? whdm_pkg::OUT_IDX_W'(r_best_idx)
                                                    : '0;
                        r_out_item.best_distance <= r_best;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    // The fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REFS))
        else $error("store fill count exceeds depth");

    // A scan only reads entries below the fill count
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_addr) < r_count))
        else $error("scan read beyond stored entries");

    // A result is matched exactly when its distance is below the no-match value
    a_match_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.matched
                         == (o_out_item.best_distance != whdm_pkg::NO_MATCH_DIST)))
        else $error("matched flag disagrees with best distance");

    // No distance candidate arrives while the block is idle
    a_cand_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_cand.valid)
        else $error("distance candidate outside a scan");
`endif

endmodule
